// ===== sv/rpcv_pkg.sv =====
// ----------------------------------------------------------------------------
// rpcv_pkg: shared types and constants of the RGB pulse color vote classifier
// Class and color codes, register indexes, reset values and field widths.
// ----------------------------------------------------------------------------
package rpcv_pkg;

  localparam int SAMPLE_BITS_DEFAULT = 16;
  localparam int FIELD_BITS          = 16;  // width of each pulse width field
  localparam int LIMIT_BITS          = 18;  // sum limit registers
  localparam int DIFF_BITS           = 16;  // difference registers
  localparam int COUNT_BITS          = 6;   // vote and reading counters
  localparam int CFG_DATA_BITS       = LIMIT_BITS;
  localparam int CFG_INDEX_BITS      = 3;

  typedef enum logic [2:0] {
    CLS_NO_OBJECT    = 3'd0,
    CLS_SENSOR_ERROR = 3'd1,
    CLS_WHITE_GRAY   = 3'd2,
    CLS_GREEN        = 3'd3,
    CLS_RED          = 3'd4,
    CLS_BLUE         = 3'd5,
    CLS_UNKNOWN      = 3'd6
  } class_t;

  typedef enum logic [1:0] {
    COLOR_RED     = 2'd0,
    COLOR_GREEN   = 2'd1,
    COLOR_BLUE    = 2'd2,
    COLOR_UNKNOWN = 2'd3
  } color_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_NO_OBJECT_LIMIT    = 3'd0,
    REG_SENSOR_ERROR_LIMIT = 3'd1,
    REG_GRAY_TOLERANCE     = 3'd2,
    REG_RED_BLUE_MIN_DIFF  = 3'd3,
    REG_GREEN_MIN_DIFF     = 3'd4,
    REG_SPREAD_LIMIT       = 3'd5,
    REG_MIN_VOTES          = 3'd6,
    REG_READINGS_PER_DEC   = 3'd7
  } reg_index_t;

  localparam logic [LIMIT_BITS-1:0] NO_OBJECT_LIMIT_RST    = 18'd3000;
  localparam logic [LIMIT_BITS-1:0] SENSOR_ERROR_LIMIT_RST = 18'd100;
  localparam logic [DIFF_BITS-1:0]  GRAY_TOLERANCE_RST     = 16'd8;
  localparam logic [DIFF_BITS-1:0]  RED_BLUE_MIN_DIFF_RST  = 16'd15;
  localparam logic [DIFF_BITS-1:0]  GREEN_MIN_DIFF_RST     = 16'd10;
  localparam logic [DIFF_BITS-1:0]  SPREAD_LIMIT_RST       = 16'd20;
  localparam logic [COUNT_BITS-1:0] MIN_VOTES_RST          = 6'd3;
  localparam logic [COUNT_BITS-1:0] READINGS_PER_DEC_RST   = 6'd10;

endpackage

// ===== sv/rpcv_in_if.sv =====
// ----------------------------------------------------------------------------
// rpcv_in_if: sensor reading channel
// Valid/ready channel carrying one red, green and blue pulse width reading.
// ----------------------------------------------------------------------------
interface rpcv_in_if import rpcv_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] red_width;
  logic [FIELD_BITS-1:0] green_width;
  logic [FIELD_BITS-1:0] blue_width;

  modport source (output valid, output red_width, output green_width,
                  output blue_width, input ready);
  modport sink   (input valid, input red_width, input green_width,
                  input blue_width, output ready);
endinterface

// ===== sv/rpcv_out_if.sv =====
// ----------------------------------------------------------------------------
// rpcv_out_if: classification result channel
// Valid/ready channel carrying the reading class and the round decision.
// ----------------------------------------------------------------------------
interface rpcv_out_if import rpcv_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] reading_class;
  logic       decision_valid;
  logic [1:0] final_color;

  modport source (output valid, output reading_class, output decision_valid,
                  output final_color, input ready);
  modport sink   (input valid, input reading_class, input decision_valid,
                  input final_color, output ready);
endinterface

// ===== sv/rgb_pulse_color_vote_classifier_core.sv =====
// ----------------------------------------------------------------------------
// rgb_pulse_color_vote_classifier_core: color classifier with majority vote
// Classifies each RGB pulse width reading and votes over a round of readings.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+--------------------------------------------
//  sample   | in  | valid / ready | red_width, green_width, blue_width
//  result   | out | valid / ready | reading_class, decision_valid, final_color
//  cfg      | in  | cfg_we        | cfg_index, cfg_data
//
//  Two registers: the reading register, then classify and vote into the
//  result register. One reading per cycle is sustained while the result is
//  accepted; vote counters update as a reading moves into the result register.
//  Synchronous reset restores register defaults and clears counters.
//  A stalled result holds the pipe; the reading register still refills once
//  the result register frees, so transfers go back to back.
// ----------------------------------------------------------------------------
module rgb_pulse_color_vote_classifier_core import rpcv_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  rpcv_in_if.sink                   sample,
  rpcv_out_if.source                result,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int SW = (SAMPLE_BITS < FIELD_BITS) ? SAMPLE_BITS : FIELD_BITS;
  localparam int TW = SW + 2;   // sum of three samples
  localparam int MW = SW + 6;   // scaled products

  // configuration registers
  logic [LIMIT_BITS-1:0] no_object_limit;
  logic [LIMIT_BITS-1:0] sensor_error_limit;
  logic [DIFF_BITS-1:0]  gray_tolerance;
  logic [DIFF_BITS-1:0]  red_blue_min_difference;
  logic [DIFF_BITS-1:0]  green_min_difference;
  logic [DIFF_BITS-1:0]  spread_limit;
  logic [COUNT_BITS-1:0] min_votes;
  logic [COUNT_BITS-1:0] readings_per_decision;

  always_ff @(posedge clk) begin
    if (rst) begin
      no_object_limit         <= NO_OBJECT_LIMIT_RST;
      sensor_error_limit      <= SENSOR_ERROR_LIMIT_RST;
      gray_tolerance          <= GRAY_TOLERANCE_RST;
      red_blue_min_difference <= RED_BLUE_MIN_DIFF_RST;
      green_min_difference    <= GREEN_MIN_DIFF_RST;
      spread_limit            <= SPREAD_LIMIT_RST;
      min_votes               <= MIN_VOTES_RST;
      readings_per_decision   <= READINGS_PER_DEC_RST;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_NO_OBJECT_LIMIT:    no_object_limit <= cfg_data;
        REG_SENSOR_ERROR_LIMIT: sensor_error_limit <= cfg_data;
        REG_GRAY_TOLERANCE:     gray_tolerance <= cfg_data[DIFF_BITS-1:0];
        REG_RED_BLUE_MIN_DIFF:  red_blue_min_difference <= cfg_data[DIFF_BITS-1:0];
        REG_GREEN_MIN_DIFF:     green_min_difference <= cfg_data[DIFF_BITS-1:0];
        REG_SPREAD_LIMIT:       spread_limit <= cfg_data[DIFF_BITS-1:0];
        REG_MIN_VOTES:          min_votes <= cfg_data[COUNT_BITS-1:0];
        REG_READINGS_PER_DEC:   readings_per_decision <= cfg_data[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic          s1_valid;
  logic          out_valid;
  logic          advance;
  logic          s1_ready;
  logic          take;
  logic [SW-1:0] r;
  logic [SW-1:0] g;
  logic [SW-1:0] b;

  assign advance  = s1_valid && (!out_valid || result.ready);
  assign s1_ready = !s1_valid || advance;
  assign take     = sample.valid && s1_ready;
  assign sample.ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      r <= sample.red_width[SW-1:0];
      g <= sample.green_width[SW-1:0];
      b <= sample.blue_width[SW-1:0];
    end
  end

  // classification
  logic [TW-1:0]        total;
  logic [LIMIT_BITS-1:0] total_x;
  logic [SW-1:0]        drg, drb, dgb, dmax;
  logic [DIFF_BITS-1:0] drg_x, drb_x, dgb_x, dmax_x;
  logic [MW-1:0]        r_x, g_x, b_x, t_x;
  logic [MW-1:0]        r9, b9, g10, r5, b5, r4, g4, b4, rb10, g21;
  logic [MW-1:0]        d20_rg, d20_bg, d20_gr, d20_br, d20_rb, d20_gb;
  logic                 g_min, g_least, r_least, b_least;
  class_t               cls;

  always_comb begin
    total   = TW'(r) + TW'(g) + TW'(b);
    total_x = LIMIT_BITS'(total);
    drg     = (r > g) ? r - g : g - r;
    drb     = (r > b) ? r - b : b - r;
    dgb     = (g > b) ? g - b : b - g;
    dmax    = (drg > drb) ? drg : drb;
    if (dgb > dmax) begin
      dmax = dgb;
    end
    drg_x  = DIFF_BITS'(drg);
    drb_x  = DIFF_BITS'(drb);
    dgb_x  = DIFF_BITS'(dgb);
    dmax_x = DIFF_BITS'(dmax);

    r_x  = MW'(r);
    g_x  = MW'(g);
    b_x  = MW'(b);
    t_x  = MW'(total);
    r9   = r_x * MW'(9);
    b9   = b_x * MW'(9);
    g10  = g_x * MW'(10);
    r5   = r_x * MW'(5);
    b5   = b_x * MW'(5);
    r4   = r_x << 2;
    g4   = g_x << 2;
    b4   = b_x << 2;
    rb10 = (r_x + b_x) * MW'(10);
    g21  = g_x * MW'(21);
    // subtractions below only matter when the subtrahend is strictly smallest
    d20_rg = (r_x - g_x) * MW'(20);
    d20_bg = (b_x - g_x) * MW'(20);
    d20_gr = (g_x - r_x) * MW'(20);
    d20_br = (b_x - r_x) * MW'(20);
    d20_rb = (r_x - b_x) * MW'(20);
    d20_gb = (g_x - b_x) * MW'(20);

    g_min   = (g <= r) && (g <= b);
    g_least = (g < r) && (g < b);
    r_least = (r < g) && (r < b);
    b_least = (b < r) && (b < g);

    if (total_x > no_object_limit) begin
      cls = CLS_NO_OBJECT;
    end else if (total_x < sensor_error_limit) begin
      cls = CLS_SENSOR_ERROR;
    end else if (drg_x < gray_tolerance && drb_x < gray_tolerance &&
                 dgb_x < gray_tolerance) begin
      cls = CLS_WHITE_GRAY;
    end else if (g_min && (drg_x > green_min_difference || dgb_x > green_min_difference)
                 && (g10 < r9 || g10 < b9)) begin
      cls = CLS_GREEN;
    end else if (g_least && rb10 > g21) begin
      cls = CLS_GREEN;
    end else if (r_least && drg_x > red_blue_min_difference &&
                 drb_x > red_blue_min_difference && r5 < g4 && r5 < b4) begin
      cls = CLS_RED;
    end else if (b_least && drb_x > red_blue_min_difference &&
                 dgb_x > red_blue_min_difference && b5 < r4 && b5 < g4) begin
      cls = CLS_BLUE;
    end else if (dmax_x > spread_limit && g_least && d20_rg > t_x && d20_bg > t_x) begin
      cls = CLS_GREEN;
    end else if (dmax_x > spread_limit && r_least && d20_gr > t_x && d20_br > t_x) begin
      cls = CLS_RED;
    end else if (dmax_x > spread_limit && b_least && d20_rb > t_x && d20_gb > t_x) begin
      cls = CLS_BLUE;
    end else begin
      cls = CLS_UNKNOWN;
    end
  end

  // voting
  logic [COUNT_BITS-1:0] red_votes, green_votes, blue_votes, readings_taken;
  logic [COUNT_BITS-1:0] red_votes_next, green_votes_next, blue_votes_next;
  logic [COUNT_BITS-1:0] readings_taken_next;
  logic                  round_done;
  color_t                color;

  always_comb begin
    red_votes_next      = red_votes + COUNT_BITS'(cls == CLS_RED);
    green_votes_next    = green_votes + COUNT_BITS'(cls == CLS_GREEN);
    blue_votes_next     = blue_votes + COUNT_BITS'(cls == CLS_BLUE);
    readings_taken_next = readings_taken + COUNT_BITS'(1);
    round_done          = readings_taken_next >= readings_per_decision;
    if (!round_done) begin
      color = COLOR_UNKNOWN;
    end else if (red_votes_next >= green_votes_next && red_votes_next >= blue_votes_next
                 && red_votes_next >= min_votes) begin
      color = COLOR_RED;
    end else if (green_votes_next >= red_votes_next &&
                 green_votes_next >= blue_votes_next && green_votes_next >= min_votes) begin
      color = COLOR_GREEN;
    end else if (blue_votes_next >= red_votes_next &&
                 blue_votes_next >= green_votes_next && blue_votes_next >= min_votes) begin
      color = COLOR_BLUE;
    end else begin
      color = COLOR_UNKNOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      red_votes      <= '0;
      green_votes    <= '0;
      blue_votes     <= '0;
      readings_taken <= '0;
    end else if (advance) begin
      if (round_done) begin
        red_votes      <= '0;
        green_votes    <= '0;
        blue_votes     <= '0;
        readings_taken <= '0;
      end else begin
        red_votes      <= red_votes_next;
        green_votes    <= green_votes_next;
        blue_votes     <= blue_votes_next;
        readings_taken <= readings_taken_next;
      end
    end
  end

  // result register
  logic [2:0] reading_class;
  logic       decision_valid;
  logic [1:0] final_color;

  always_ff @(posedge clk) begin
    if (advance) begin
      reading_class  <= cls;
      decision_valid <= round_done;
      final_color    <= color;
    end
  end

  assign result.valid          = out_valid;
  assign result.reading_class  = reading_class;
  assign result.decision_valid = decision_valid;
  assign result.final_color    = final_color;

endmodule
